FILE: rtl/hsvrgb_pkg.sv
// Package for the HSV to RGB converter: hue geometry constants and the sector type.
// No dependencies; used by the interfaces and imported by every module.
`timescale 1ns / 1ps

package hsvrgb_pkg;

  localparam int unsigned CHANNEL_BITS_DEF = 8;
  localparam int unsigned HUE_W            = 16;
  localparam int unsigned FRAC_W           = 12;     // holds 0..3840
  localparam int unsigned SECTOR_UNITS     = 3840;   // 60 degrees in 1/64 degree units
  localparam int unsigned TURN_UNITS       = 23040;  // full turn
  localparam int unsigned NUM_SECTORS      = 6;
  // SECTOR_UNITS = SECTOR_ODD << SECTOR_SHIFT
  localparam int unsigned SECTOR_SHIFT     = 8;
  localparam int unsigned SECTOR_ODD       = 15;

  typedef enum logic [2:0] {
    SEC_R_Y = 3'd0,
    SEC_Y_G = 3'd1,
    SEC_G_C = 3'd2,
    SEC_C_B = 3'd3,
    SEC_B_M = 3'd4,
    SEC_M_R = 3'd5
  } sector_e;

endpackage

FILE: rtl/hsvrgb_in_if.sv
// Valid/ready channel carrying one HSV pixel per transfer.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

interface hsvrgb_in_if #(
  parameter int unsigned CHANNEL_BITS = hsvrgb_pkg::CHANNEL_BITS_DEF
);
  import hsvrgb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [HUE_W-1:0]        hue;
  logic [CHANNEL_BITS-1:0] saturation;
  logic [CHANNEL_BITS-1:0] brightness_value;

  modport source (output valid, hue, saturation, brightness_value, input ready);
  modport sink   (input valid, hue, saturation, brightness_value, output ready);
endinterface

FILE: rtl/hsvrgb_out_if.sv
// Valid/ready channel carrying one RGB pixel per transfer.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

interface hsvrgb_out_if #(
  parameter int unsigned CHANNEL_BITS = hsvrgb_pkg::CHANNEL_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

FILE: rtl/hsvrgb_lane.sv
// One arithmetic lane: q = floor(v * (FULL*3840 - s*x) / (FULL*3840)), four register stages.
// Constant division by reciprocal multiply plus one correction step. Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_lane #(
  parameter int unsigned CHANNEL_BITS = hsvrgb_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic [3:0]                           en_i,
  input  logic [CHANNEL_BITS-1:0]              s_i,
  input  logic [CHANNEL_BITS-1:0]              v_i,
  input  logic [hsvrgb_pkg::FRAC_W-1:0]        x_i,
  output logic [CHANNEL_BITS-1:0]              q_o
);
  import hsvrgb_pkg::*;

  localparam int unsigned     C    = CHANNEL_BITS;
  localparam longint unsigned FULL = (64'd1 << C) - 64'd1;
  localparam longint unsigned DEN  = FULL * SECTOR_UNITS;
  localparam int unsigned     SX_W = C + FRAC_W;
  localparam int unsigned     X_W  = 2 * C + FRAC_W;
  localparam int unsigned     Y_W  = X_W - SECTOR_SHIFT;
  localparam longint unsigned DIV  = SECTOR_ODD * FULL;
  localparam int unsigned     K    = Y_W;
  localparam longint unsigned RECP = (64'd1 << K) / DIV;
  localparam int unsigned     M_W  = C + 1;
  localparam int unsigned     P_W  = Y_W + M_W;

  logic [SX_W-1:0] sx_q;
  logic [C-1:0]    v1_q;
  logic [SX_W-1:0] num_w;
  logic [X_W-1:0]  x_q;
  logic [Y_W-1:0]  y3_q, y4_q;
  logic [P_W-1:0]  prod_q;
  logic [M_W-1:0]  qe_q;
  logic [Y_W-1:0]  rem_w;
  logic [M_W-1:0]  qc_w;

  assign num_w = SX_W'(DEN) - sx_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sx_q <= {{FRAC_W{1'b0}}, s_i} * {{C{1'b0}}, x_i};
      v1_q <= v_i;
    end
    if (en_i[1]) begin
      x_q <= {{(X_W - C){1'b0}}, v1_q} * {{(X_W - SX_W){1'b0}}, num_w};
    end
    if (en_i[2]) begin
      y3_q   <= x_q[X_W-1:SECTOR_SHIFT];
      prod_q <= {{M_W{1'b0}}, x_q[X_W-1:SECTOR_SHIFT]} * P_W'(RECP);
    end
    if (en_i[3]) begin
      qe_q <= prod_q[P_W-1:K];
      y4_q <= y3_q;
    end
  end

  // estimate is exact or one low
  always_comb begin
    rem_w = y4_q - ({{(Y_W - M_W){1'b0}}, qe_q} * Y_W'(DIV));
    qc_w  = (rem_w >= Y_W'(DIV)) ? qe_q + M_W'(1) : qe_q;
  end

  assign q_o = qc_w[C-1:0];

endmodule

FILE: rtl/hsv_to_rgb_converter_unit.sv
// HSV to RGB pixel converter. Accepts one pixel per clock unless the output stalls, and registers
// each result through a sector stage, four stages of the three division lanes (product,
// scale, reciprocal multiply, estimate) and the output register. Every stage stalls on its own,
// so bubbles fill up behind a stalled output. Depends on hsvrgb_pkg, the interfaces and hsvrgb_lane.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_unit #(
  parameter int unsigned CHANNEL_BITS = hsvrgb_pkg::CHANNEL_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hsvrgb_in_if.sink    hsv_i,
  hsvrgb_out_if.source rgb_o
);
  import hsvrgb_pkg::*;

  localparam int unsigned C       = CHANNEL_BITS;
  localparam int unsigned NSTG    = 6;
  localparam int unsigned OUT_STG = NSTG - 1;

  typedef struct packed {
    sector_e      sector;
    logic         zero;
    logic [C-1:0] v;
  } side_t;

  logic [NSTG-1:0]   valid_q;
  logic [NSTG-1:0]   en_w;
  side_t             side_q [OUT_STG];
  logic [C-1:0]      s0_q;
  logic [FRAC_W-1:0] frac0_q;
  logic [HUE_W-1:0]  hue_w;
  logic [2:0]        sect_w;
  logic [FRAC_W-1:0] frac_w;
  logic [FRAC_W-1:0] xt_w;
  logic [C-1:0]      p_w, q_w, t_w;
  logic [C-1:0]      red_d, green_d, blue_d;
  logic [C-1:0]      red_q, green_q, blue_q;

  always_comb begin
    en_w[OUT_STG] = !valid_q[OUT_STG] || rgb_o.ready;
    for (int i = OUT_STG - 1; i >= 0; i--) begin
      en_w[i] = !valid_q[i] || en_w[i+1];
    end
  end

  assign hsv_i.ready = en_w[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en_w[0]) valid_q[0] <= hsv_i.valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en_w[i]) valid_q[i] <= valid_q[i-1];
      end
    end
  end

  // sector and offset within it
  always_comb begin
    hue_w  = (hsv_i.hue >= HUE_W'(TURN_UNITS)) ? '0 : hsv_i.hue;
    sect_w = '0;
    for (int k = 1; k < NUM_SECTORS; k++) begin
      if (hue_w >= HUE_W'(k * SECTOR_UNITS)) sect_w = 3'(k);
    end
    frac_w = FRAC_W'(hue_w - HUE_W'(sect_w * SECTOR_UNITS));
  end

  always_ff @(posedge clk_i) begin
    if (en_w[0]) begin
      side_q[0].sector <= sector_e'(sect_w);
      side_q[0].zero   <= (hsv_i.saturation == '0);
      side_q[0].v      <= hsv_i.brightness_value;
      s0_q             <= hsv_i.saturation;
      frac0_q          <= frac_w;
    end
    for (int i = 1; i < OUT_STG; i++) begin
      if (en_w[i]) side_q[i] <= side_q[i-1];
    end
  end

  assign xt_w = FRAC_W'(SECTOR_UNITS) - frac0_q;

  hsvrgb_lane #(.CHANNEL_BITS(C)) u_lane_p (
    .clk_i (clk_i),
    .en_i  (en_w[4:1]),
    .s_i   (s0_q),
    .v_i   (side_q[0].v),
    .x_i   (FRAC_W'(SECTOR_UNITS)),
    .q_o   (p_w)
  );

  hsvrgb_lane #(.CHANNEL_BITS(C)) u_lane_q (
    .clk_i (clk_i),
    .en_i  (en_w[4:1]),
    .s_i   (s0_q),
    .v_i   (side_q[0].v),
    .x_i   (frac0_q),
    .q_o   (q_w)
  );

  hsvrgb_lane #(.CHANNEL_BITS(C)) u_lane_t (
    .clk_i (clk_i),
    .en_i  (en_w[4:1]),
    .s_i   (s0_q),
    .v_i   (side_q[0].v),
    .x_i   (xt_w),
    .q_o   (t_w)
  );

  always_comb begin
    if (side_q[OUT_STG-1].zero) begin
      red_d   = side_q[OUT_STG-1].v;
      green_d = side_q[OUT_STG-1].v;
      blue_d  = side_q[OUT_STG-1].v;
    end else begin
      case (side_q[OUT_STG-1].sector)
        SEC_R_Y: begin
          red_d = side_q[OUT_STG-1].v; green_d = t_w; blue_d = p_w;
        end
        SEC_Y_G: begin
          red_d = q_w; green_d = side_q[OUT_STG-1].v; blue_d = p_w;
        end
        SEC_G_C: begin
          red_d = p_w; green_d = side_q[OUT_STG-1].v; blue_d = t_w;
        end
        SEC_C_B: begin
          red_d = p_w; green_d = q_w; blue_d = side_q[OUT_STG-1].v;
        end
        SEC_B_M: begin
          red_d = t_w; green_d = p_w; blue_d = side_q[OUT_STG-1].v;
        end
        default: begin
          red_d = side_q[OUT_STG-1].v; green_d = p_w; blue_d = q_w;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_w[OUT_STG]) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign rgb_o.valid = valid_q[OUT_STG];
  assign rgb_o.red   = red_q;
  assign rgb_o.green = green_q;
  assign rgb_o.blue  = blue_q;

  a_gray_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_w[OUT_STG] && valid_q[OUT_STG-1] && side_q[OUT_STG-1].zero)
    |=> (red_q == green_q && green_q == blue_q))
    else $error("zero saturation pixel not gray");

  a_max_is_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_w[OUT_STG] && valid_q[OUT_STG-1])
    |=> (red_q == $past(side_q[OUT_STG-1].v) || green_q == $past(side_q[OUT_STG-1].v)
         || blue_q == $past(side_q[OUT_STG-1].v)))
    else $error("no channel carries the value");

  a_room_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[0] |-> hsv_i.ready)
    else $error("input stalled with an empty first stage");

  a_lane_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[OUT_STG-1] |-> (p_w <= side_q[OUT_STG-1].v && q_w <= side_q[OUT_STG-1].v
                            && t_w <= side_q[OUT_STG-1].v))
    else $error("lane quotient exceeds value");

endmodule

FILE: bench/rgb_pixel_checker.sv
// Checker for the HSV to RGB converter: watches both channels, computes each expected RGB pixel
// and compares it with the next output transfer. Depends on hsvrgb_pkg and the channel interfaces.
`timescale 1ns / 1ps

module rgb_pixel_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  hsvrgb_in_if        hsv_ch,
  hsvrgb_out_if       rgb_ch,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  import hsvrgb_pkg::*;

  localparam int unsigned CB = CHANNEL_BITS_DEF;
  localparam longint unsigned FULL = (64'd1 << CB) - 64'd1;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CB-1:0]    sat;
    logic [CB-1:0]    val;
    logic [CB-1:0]    red;
    logic [CB-1:0]    green;
    logic [CB-1:0]    blue;
  } rgb_expect_t;

  rgb_expect_t expected_rgb_q[$];
  int unsigned mismatches;

  function automatic rgb_expect_t hsv_to_rgb_pixel(logic [HUE_W-1:0] hue, logic [CB-1:0] sat,
                                                   logic [CB-1:0] val);
    longint unsigned h, s, v, frac, den, p, q, t;
    logic [CB-1:0] pv, qv, tv;
    sector_e sec;
    rgb_expect_t px;
    px.hue = hue;
    px.sat = sat;
    px.val = val;
    h = hue;
    s = sat;
    v = val;
    if (s == 0) begin
      px.red = val;
      px.green = val;
      px.blue = val;
      return px;
    end
    if (h >= TURN_UNITS) h = 0;
    sec  = sector_e'(h / SECTOR_UNITS);
    frac = h % SECTOR_UNITS;
    den  = FULL * SECTOR_UNITS;
    p = (v * (FULL - s)) / FULL;
    q = (v * (den - s * frac)) / den;
    t = (v * (den - s * (SECTOR_UNITS - frac))) / den;
    pv = p[CB-1:0];
    qv = q[CB-1:0];
    tv = t[CB-1:0];
    case (sec)
      SEC_R_Y: begin px.red = val; px.green = tv;  px.blue = pv;  end
      SEC_Y_G: begin px.red = qv;  px.green = val; px.blue = pv;  end
      SEC_G_C: begin px.red = pv;  px.green = val; px.blue = tv;  end
      SEC_C_B: begin px.red = pv;  px.green = qv;  px.blue = val; end
      SEC_B_M: begin px.red = tv;  px.green = pv;  px.blue = val; end
      default: begin px.red = val; px.green = pv;  px.blue = qv;  end
    endcase
    return px;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rgb_expect_t exp_px;
    if (!rst_ni) begin
      expected_rgb_q.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (hsv_ch.valid && hsv_ch.ready)
        expected_rgb_q.push_back(hsv_to_rgb_pixel(hsv_ch.hue, hsv_ch.saturation,
                                                  hsv_ch.brightness_value));
      if (rgb_ch.valid && rgb_ch.ready) begin
        if (expected_rgb_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected RGB transfer r=%0d g=%0d b=%0d", $realtime,
                     rgb_ch.red, rgb_ch.green, rgb_ch.blue);
        end else begin
          exp_px = expected_rgb_q.pop_front();
          if (rgb_ch.red !== exp_px.red || rgb_ch.green !== exp_px.green ||
              rgb_ch.blue !== exp_px.blue) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: hsv=(%0d,%0d,%0d) expected rgb=(%0d,%0d,%0d) got (%0d,%0d,%0d)",
                       $realtime, exp_px.hue, exp_px.sat, exp_px.val, exp_px.red,
                       exp_px.green, exp_px.blue, rgb_ch.red, rgb_ch.green, rgb_ch.blue);
          end
        end
      end
      mismatch_count_o <= mismatches;
      pending_o <= expected_rgb_q.size();
    end
  end

endmodule

FILE: bench/tb_hsv_to_rgb_converter_unit.sv
// HSV to RGB converter testbench top: drives fixed HSV pixels, then random bursts, stalls the
// RGB side, and reports the verdict. Depends on hsvrgb_pkg, the interfaces and rgb_pixel_checker.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter_unit;
  import hsvrgb_pkg::*;

  localparam int unsigned CB = CHANNEL_BITS_DEF;
  localparam int unsigned RANDOM_PIXELS = 1400;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_COIN,
    STALL_RARE,
    STALL_PERIODIC
  } stall_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned mismatch_count;
  int unsigned pending_count;

  hsvrgb_in_if  hsv_if ();
  hsvrgb_out_if rgb_if ();

  hsv_to_rgb_converter_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hsv_i  (hsv_if),
    .rgb_o  (rgb_if)
  );

  rgb_pixel_checker chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .hsv_ch           (hsv_if),
    .rgb_ch           (rgb_if),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  always #1 clk_i = ~clk_i;

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic put_pixel(logic [HUE_W-1:0] hue, logic [CB-1:0] sat, logic [CB-1:0] val);
    hsv_if.valid <= 1'b1;
    hsv_if.hue <= hue;
    hsv_if.saturation <= sat;
    hsv_if.brightness_value <= val;
    @(posedge clk_i);
    while (!hsv_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      hsv_if.valid <= 1'b0;
      hsv_if.hue <= HUE_W'($urandom);
      hsv_if.saturation <= CB'($urandom);
      hsv_if.brightness_value <= CB'($urandom);
      @(negedge clk_i);
    end
  endtask

  function automatic logic [HUE_W-1:0] random_hue();
    logic [HUE_W-1:0] h;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: h = HUE_W'($urandom_range(0, TURN_UNITS - 1));
      6, 7:             h = HUE_W'($urandom_range(TURN_UNITS, 65535));
      8:                h = HUE_W'($urandom_range(0, NUM_SECTORS) * SECTOR_UNITS
                                   + $urandom_range(0, 2) - 1);
      default:          h = HUE_W'($urandom);
    endcase
    return h;
  endfunction

  function automatic logic [CB-1:0] random_chan();
    logic [CB-1:0] c;
    case ($urandom_range(0, 9))
      0:       c = '0;
      1:       c = '1;
      2:       c = CB'(1);
      default: c = CB'($urandom);
    endcase
    return c;
  endfunction

  // RGB side back-pressure, switching to a randomly chosen pattern after each random span
  initial begin
    stall_mode_e mode;
    int unsigned span;
    int unsigned phase;
    rgb_if.ready = 1'b0;
    phase = 0;
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk_i);
        phase++;
        case (mode)
          STALL_NONE:  rgb_if.ready <= 1'b1;
          STALL_COIN:  rgb_if.ready <= 1'($urandom_range(0, 1));
          STALL_RARE:  rgb_if.ready <= ($urandom_range(0, 9) != 0);
          default:     rgb_if.ready <= ((phase % 7) >= 3);
        endcase
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned burst;
    hsv_if.valid = 1'b0;
    hsv_if.hue = '0;
    hsv_if.saturation = '0;
    hsv_if.brightness_value = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero saturation, extremes of value
    put_pixel(16'd0, 8'd0, 8'd0);
    put_pixel(16'd0, 8'd0, 8'd255);
    put_pixel(16'd12345, 8'd0, 8'd128);
    put_pixel(16'd65535, 8'd0, 8'd77);
    // every sector and some of its edges
    put_pixel(16'd0, 8'd255, 8'd255);
    put_pixel(16'd1, 8'd255, 8'd255);
    put_pixel(16'd1920, 8'd255, 8'd255);
    put_pixel(16'd3839, 8'd255, 8'd255);
    put_pixel(16'd3840, 8'd255, 8'd255);
    put_pixel(16'd7679, 8'd200, 8'd255);
    put_pixel(16'd7680, 8'd128, 8'd200);
    put_pixel(16'd11520, 8'd1, 8'd255);
    put_pixel(16'd15360, 8'd255, 8'd1);
    put_pixel(16'd19200, 8'd170, 8'd85);
    put_pixel(16'd21845, 8'd85, 8'd170);
    put_pixel(16'd23039, 8'd255, 8'd255);
    // hue at or past a full turn
    put_pixel(16'd23040, 8'd200, 8'd77);
    put_pixel(16'd43690, 8'd255, 8'd255);
    put_pixel(16'd65535, 8'd255, 8'd255);
    put_pixel(16'd65535, 8'd1, 8'd1);
    // zero value with full saturation, then near-full saturation and value
    put_pixel(16'd5000, 8'd255, 8'd0);
    put_pixel(16'd17000, 8'd254, 8'd254);
    idle_cycles(3);

    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        put_pixel(random_hue(), random_chan(), random_chan());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end
    idle_cycles(1);

    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
rtl/hsvrgb_pkg.sv
rtl/hsvrgb_in_if.sv
rtl/hsvrgb_out_if.sv
rtl/hsvrgb_lane.sv
rtl/hsv_to_rgb_converter_unit.sv
bench/rgb_pixel_checker.sv
bench/tb_hsv_to_rgb_converter_unit.sv
